// ===== src/grid_shortest_path_tree_macros.svh =====
// Assertion macros shared by the grid shortest path tree modules.
`ifndef GRID_SHORTEST_PATH_TREE_MACROS_SVH
`define GRID_SHORTEST_PATH_TREE_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define GSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define GSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/gsp_pkg.sv =====
// Package: sizes, item codes and interface types of the grid shortest path tree.
package gsp_pkg;

  localparam int unsigned NODE_COUNT     = 16;
  localparam int unsigned SLOTS_PER_NODE = 4;
  localparam int unsigned NODE_W         = 4;
  localparam int unsigned SLOT_W         = 2;
  localparam int unsigned DIST_W         = 4;
  localparam int unsigned ENTRY_COUNT    = NODE_COUNT * SLOTS_PER_NODE;
  localparam int unsigned ENTRY_W        = NODE_W + SLOT_W;

  localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODE_COUNT - 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS_PER_NODE - 1);

  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_CLEAR  = 2'd1;
  localparam logic [1:0] KIND_SEARCH = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [NODE_W-1:0] node;
    logic [SLOT_W-1:0] slot;
    logic [NODE_W-1:0] neighbour;
    logic              slot_used;
  } gsp_in_t;

  typedef struct packed {
    logic [NODE_W-1:0] node_id;
    logic [NODE_W-1:0] predecessor;
    logic [DIST_W-1:0] distance;
    logic              reachable;
    logic              last;
  } gsp_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic              wr_slot;
    logic              clr_row;
    logic              search_go;
    logic              init;
    logic              scan;
    logic              scan_first;
    logic              pick;
    logic              rd_en;
    logic              out_en;
    logic              out_last;
    logic [NODE_W-1:0] idx;
  } gsp_cmd_t;

  typedef struct packed {
    logic found;
  } gsp_sts_t;

endpackage

// ===== src/gsp_ctrl.sv =====
// Controller: sequences init, minimum scan, pick, relaxation and result emission.
`include "grid_shortest_path_tree_macros.svh"

module gsp_ctrl
  import gsp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] kind_i,
  input  gsp_sts_t   sts_i,
  output gsp_cmd_t   cmd_o,
  output logic       busy_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_SCAN,
    S_PICK,
    S_RELAX,
    S_DRAIN,
    S_EMIT
  } state_e;

  state_e            state_q, state_d;
  logic [NODE_W-1:0] cnt_q, cnt_d;
  logic              accept;

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i && (kind_i == KIND_SEARCH)) state_d = S_INIT;
      end
      S_INIT: begin
        state_d = S_SCAN;
        cnt_d   = '0;
      end
      S_SCAN: begin
        if (cnt_q == LAST_NODE) begin
          state_d = S_PICK;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + NODE_W'(1);
        end
      end
      S_PICK: begin
        state_d = sts_i.found ? S_RELAX : S_EMIT;
        cnt_d   = '0;
      end
      S_RELAX: begin
        if (cnt_q[SLOT_W-1:0] == LAST_SLOT) begin
          state_d = S_DRAIN;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + NODE_W'(1);
        end
      end
      // lets the last slot's relaxation land before the next scan reads the flags
      S_DRAIN: begin
        state_d = S_SCAN;
        cnt_d   = '0;
      end
      S_EMIT: begin
        if (cnt_q == LAST_NODE) begin
          state_d = S_IDLE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + NODE_W'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.wr_slot    = accept && (kind_i == KIND_WRITE);
    cmd_o.clr_row    = accept && (kind_i == KIND_CLEAR);
    cmd_o.search_go  = accept && (kind_i == KIND_SEARCH);
    cmd_o.init       = (state_q == S_INIT);
    cmd_o.scan       = (state_q == S_SCAN);
    cmd_o.scan_first = (state_q == S_SCAN) && (cnt_q == '0);
    cmd_o.pick       = (state_q == S_PICK) && sts_i.found;
    cmd_o.rd_en      = (state_q == S_RELAX);
    cmd_o.out_en     = (state_q == S_EMIT);
    cmd_o.out_last   = (state_q == S_EMIT) && (cnt_q == LAST_NODE);
    cmd_o.idx        = cnt_q;
  end

  `GSP_ASSERT_NXT(a_go_init, cmd_o.search_go, state_q == S_INIT, "search transfer did not start init")
  `GSP_ASSERT_NXT(a_emit_end, cmd_o.out_last, state_q == S_IDLE, "controller busy after last result")
  `GSP_ASSERT_IMP(a_pick_exit, (state_q == S_PICK) && !sts_i.found, !cmd_o.pick, "pick with nothing found")

endmodule

// ===== src/gsp_datapath.sv =====
// Datapath: neighbour table, search flags, distance and predecessor stores, result register.
`include "grid_shortest_path_tree_macros.svh"

module gsp_datapath
  import gsp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  gsp_in_t  item_i,
  input  gsp_cmd_t cmd_i,
  output gsp_sts_t sts_o,
  output gsp_out_t result_o,
  output logic     result_valid_o
);

  // neighbour numbers live in a memory; the used bits are flops so reset empties the table
  logic [NODE_W-1:0]      nbr_mem [ENTRY_COUNT];
  logic [ENTRY_COUNT-1:0] slot_used_q;
  logic [NODE_W-1:0]      nb_q;
  logic                   used_q;
  logic                   rel_pend_q;

  logic [NODE_COUNT-1:0]  visited_q;
  logic [NODE_COUNT-1:0]  reached_q;
  logic [NODE_W-1:0]      pred_q [NODE_COUNT];
  logic [DIST_W-1:0]      dist_q [NODE_COUNT];

  logic [NODE_W-1:0]      target_q;
  logic                   found_q;
  logic [DIST_W-1:0]      best_q;
  logic [NODE_W-1:0]      v_q;
  logic [DIST_W-1:0]      h_q;

  gsp_out_t               result_q;
  logic                   result_valid_q;

  logic [ENTRY_W-1:0]     wr_addr;
  logic [ENTRY_W-1:0]     rd_addr;
  logic                   found_eff;
  logic                   cand;
  logic                   relax_hit;

  assign wr_addr = {item_i.node, item_i.slot};
  assign rd_addr = {v_q, cmd_i.idx[SLOT_W-1:0]};

  // lowest index wins ties: only a strictly smaller distance replaces the best so far
  assign found_eff = cmd_i.scan_first ? 1'b0 : found_q;
  assign cand = reached_q[cmd_i.idx] && !visited_q[cmd_i.idx] &&
                (!found_eff || (dist_q[cmd_i.idx] < best_q));

  // Unit weights: every reached, unvisited node already sits at most one hop past the
  // picked node, so h < dist never holds and only unreached neighbours get relaxed.
  assign relax_hit = rel_pend_q && used_q && !visited_q[nb_q] && !reached_q[nb_q];

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_slot) nbr_mem[wr_addr] <= item_i.neighbour;
    if (cmd_i.rd_en) begin
      nb_q   <= nbr_mem[rd_addr];
      used_q <= slot_used_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_used_q    <= '0;
      rel_pend_q     <= 1'b0;
      visited_q      <= '0;
      reached_q      <= '0;
      result_valid_q <= 1'b0;
      for (int n = 0; n < NODE_COUNT; n++) pred_q[n] <= '0;
    end else begin
      rel_pend_q     <= cmd_i.rd_en;
      result_valid_q <= cmd_i.out_en;
      if (cmd_i.wr_slot) slot_used_q[wr_addr] <= item_i.slot_used;
      if (cmd_i.clr_row) begin
        slot_used_q <= slot_used_q &
                       ~(ENTRY_COUNT'({SLOTS_PER_NODE{1'b1}}) << {item_i.node, SLOT_W'(0)});
      end
      if (cmd_i.init) begin
        visited_q        <= '0;
        reached_q        <= NODE_COUNT'(1) << target_q;
        pred_q[target_q] <= target_q;
      end else begin
        if (cmd_i.pick) visited_q[v_q] <= 1'b1;
        if (relax_hit) begin
          reached_q[nb_q] <= 1'b1;
          pred_q[nb_q]    <= v_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.search_go) target_q <= item_i.node;
    if (cmd_i.init) begin
      dist_q[target_q] <= '0;
    end else if (relax_hit) begin
      dist_q[nb_q] <= h_q;
    end
    if (cmd_i.scan) begin
      if (cand) begin
        found_q <= 1'b1;
        best_q  <= dist_q[cmd_i.idx];
        v_q     <= cmd_i.idx;
      end else if (cmd_i.scan_first) begin
        found_q <= 1'b0;
      end
    end
    if (cmd_i.pick) h_q <= best_q + DIST_W'(1);
    if (cmd_i.out_en) begin
      result_q.node_id     <= cmd_i.idx;
      result_q.predecessor <= pred_q[cmd_i.idx];
      result_q.distance    <= reached_q[cmd_i.idx] ? dist_q[cmd_i.idx] : '0;
      result_q.reachable   <= reached_q[cmd_i.idx];
      result_q.last        <= cmd_i.out_last;
    end
  end

  assign sts_o.found    = found_q;
  assign result_o       = result_q;
  assign result_valid_o = result_valid_q;

  `GSP_ASSERT(a_visited_reached, (visited_q & ~reached_q) == '0, "visited node never reached")
  `GSP_ASSERT_IMP(a_pick_fresh, cmd_i.pick, reached_q[v_q] && !visited_q[v_q], "picked node not open")
  `GSP_ASSERT_IMP(a_last_id, result_valid_o && result_o.last, result_o.node_id == LAST_NODE, "last flag on wrong node")

endmodule

// ===== src/grid_shortest_path_tree.sv =====
// A slot write or row clear leaves busy low throughout.
// Search: init, then per reached node a minimum scan over all 16 nodes, a pick, 4 slot reads
// and a drain, a final scan and pick, then 16 results on consecutive cycles.
// Reset (async, active low): table empty, predecessors zero, controller idle.
// Results cannot be stalled; each is shown for one cycle under result_valid_o.
module grid_shortest_path_tree
  import gsp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  gsp_in_t  item_i,
  output gsp_out_t result_o,
  output logic     result_valid_o
);

  gsp_cmd_t cmd;
  gsp_sts_t sts;

  gsp_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .kind_i  (item_i.kind),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  gsp_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule
